// File: rtl/core/cle_pkg.sv
// Package for the circular list engine: codes, types and sizing constants.
`timescale 1ns / 1ps
`default_nettype none
package cle_pkg;

  localparam int unsigned CAPACITY_DEF = 32;

  typedef enum logic [3:0] {
    ACT_ADD_FIRST = 4'd0,
    ACT_ADD_LAST  = 4'd1,
    ACT_ADD_AFTER = 4'd2,
    ACT_DEL_FIRST = 4'd3,
    ACT_DEL_LAST  = 4'd4,
    ACT_LIST      = 4'd5,
    ACT_SORT      = 4'd6,
    ACT_CLEAR     = 4'd7,
    ACT_JOSEPHUS  = 4'd8
  } action_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_LISTED   = 3'd1,
    ST_ELIM     = 3'd2,
    ST_SURV     = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_FULL     = 3'd5,
    ST_NOTFOUND = 3'd6
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_LIST_RD,
    S_LIST_EMIT,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_SWAP,
    S_JOS_MOD,
    S_JOS_RD,
    S_JOS_EMIT,
    S_EMIT
  } state_t;

  // Signed 32-bit greater-than used by the sort pass.
  function automatic logic gt_signed(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) > $signed(b);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/cle_mem.sv
// Dual-port value memory with registered reads.
`timescale 1ns / 1ps
`default_nettype none
module cle_mem #(
  parameter int unsigned DEPTH = cle_pkg::CAPACITY_DEF,
  parameter int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [31:0]   rdata_a,
  output logic      [31:0]   rdata_b
);
  logic [31:0] mem [DEPTH];

  // Write one entry, read two.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

// File: rtl/core/circular_list_engine.sv
// Circular list engine: a bounded list of signed values in list order, one
// memory holding the values by position; only one request is worked on at a
// time. After the accepting edge a decode state follows. Add moves each entry
// behind the insertion point with a read and a write state, then writes the
// new value (add at the tail moves nothing); add after first searches with a
// read and a compare state per entry examined. Delete moves each entry behind
// the removed one with a read and a write state, then closes in the read state.
// List gives each entry as a result while the output is taken. Sort is an
// exchange sort of n(n-1)/2 compares, each a read and a compare state, plus a
// swap state per swap. Josephus per elimination forms the bit-serial remainder
// of the step minus one by the count, reads, gives a result and then deletes.
// Single-result requests end with a result state. Any cycle that loads a
// result waits while the result register is held; that register lets the next
// request be taken while the last result waits. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none
module circular_list_engine #(
  parameter int unsigned CAPACITY = cle_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         action,
  input  wire logic signed [31:0] value,
  input  wire logic signed [31:0] match_value,
  input  wire logic [15:0]        step,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              status,
  output logic signed [31:0]      item,
  output logic                    last
);
  import cle_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [CW-1:0] CNT_TWO  = CW'(2);
  localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);
  localparam logic [4:0]    MOD_BITS = 5'd16;

  state_t state, state_next;
  status_t ov_status_r;
  logic [3:0]    act;
  logic [31:0]   val, mval;
  logic [15:0]   km1, kshift;
  logic [CW-1:0] count;
  logic [CW-1:0] i, j;
  logic [CW-1:0] pos;
  logic [CW-1:0] rem;
  logic [4:0]    bitc;
  logic [31:0]   tmp;

  logic          we;
  logic [AW-1:0] waddr, ra, rb;
  logic [31:0]   wdata, da, db;

  logic          ov_load;
  status_t       ov_status;
  logic [31:0]   ov_item;
  logic          ov_last;
  logic          out_free;

  logic [CW:0]   rem_shift, rem_sub, pos_sum, pos_sub;
  logic          sort_swap, sort_last, at_end, ins_done, del_done, src_hit;

  cle_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr_a(ra), .raddr_b(rb),
    .rdata_a(da), .rdata_b(db)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ov_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (ov_load) begin
      status <= ov_status;
      item   <= ov_item;
      last   <= ov_last;
    end
  end
  assign out_free = !out_valid || out_ready;

  assign in_ready = (state == S_IDLE);

  // Loop conditions and remainder arithmetic.
  assign rem_shift = {rem, kshift[15]};
  assign rem_sub   = rem_shift - {1'b0, count};
  assign pos_sum   = {1'b0, pos} + {1'b0, rem};
  assign pos_sub   = pos_sum - {1'b0, count};
  assign sort_swap = gt_signed(da, db);
  assign sort_last = (j + CNT_ONE >= count) && (i + CNT_TWO >= count);
  assign at_end    = (i + CNT_ONE == count);
  assign ins_done  = (i == pos);
  assign del_done  = (i + CNT_ONE >= count);
  assign src_hit   = (da == mval);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_DECIDE;
      S_DECIDE: begin
        unique case (act) inside
          ACT_ADD_FIRST, ACT_ADD_LAST:
            state_next = (count == CNT_FULL) ? S_EMIT : S_INS_RD;
          ACT_ADD_AFTER: state_next = (count == '0) ? S_EMIT : S_SRCH_RD;
          ACT_DEL_FIRST, ACT_DEL_LAST:
            state_next = (count == '0) ? S_EMIT : S_DEL_RD;
          ACT_LIST: state_next = (count == '0) ? S_EMIT : S_LIST_RD;
          ACT_SORT: state_next = (count <= CNT_ONE) ? S_EMIT : S_SORT_RD;
          ACT_JOSEPHUS: begin
            if (count == '0) state_next = S_EMIT;
            else if (count == CNT_ONE) state_next = S_JOS_RD;
            else state_next = S_JOS_MOD;
          end
          default: state_next = S_EMIT;
        endcase
      end
      S_INS_RD:    state_next = ins_done ? S_EMIT : S_INS_WR;
      S_INS_WR:    state_next = S_INS_RD;
      S_DEL_RD: begin
        if (!del_done) state_next = S_DEL_WR;
        else if (act != ACT_JOSEPHUS) state_next = S_EMIT;
        else if (count == CNT_TWO) state_next = S_JOS_RD;
        else state_next = S_JOS_MOD;
      end
      S_DEL_WR:    state_next = S_DEL_RD;
      S_SRCH_RD:   state_next = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (src_hit) state_next = (count == CNT_FULL) ? S_EMIT : S_INS_RD;
        else state_next = at_end ? S_EMIT : S_SRCH_RD;
      end
      S_LIST_RD:   state_next = S_LIST_EMIT;
      S_LIST_EMIT: if (out_free) state_next = at_end ? S_IDLE : S_LIST_RD;
      S_SORT_RD:   state_next = S_SORT_CMP;
      S_SORT_CMP: begin
        if (sort_swap) state_next = S_SORT_SWAP;
        else state_next = sort_last ? S_EMIT : S_SORT_RD;
      end
      S_SORT_SWAP: state_next = sort_last ? S_EMIT : S_SORT_RD;
      S_JOS_MOD:   if (bitc == 5'd0) state_next = S_JOS_RD;
      S_JOS_RD:    state_next = S_JOS_EMIT;
      S_JOS_EMIT:  if (out_free) state_next = (count == CNT_ONE) ? S_IDLE : S_DEL_RD;
      S_EMIT:      if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        // Capture the request.
        S_IDLE: if (in_valid) begin
          act  <= action;
          val  <= value;
          mval <= match_value;
          km1  <= (step == 16'd0) ? 16'd0 : step - 16'd1;
        end
        // Decode and set up the walk.
        S_DECIDE: begin
          unique case (act) inside
            ACT_ADD_FIRST, ACT_ADD_LAST: begin
              ov_status_r <= (count == CNT_FULL) ? ST_FULL : ST_DONE;
              pos <= (act == ACT_ADD_FIRST) ? '0 : count;
              i   <= count;
            end
            ACT_ADD_AFTER: begin
              ov_status_r <= ST_EMPTY;
              i <= '0;
            end
            ACT_DEL_FIRST, ACT_DEL_LAST: begin
              ov_status_r <= (count == '0) ? ST_EMPTY : ST_DONE;
              pos <= (act == ACT_DEL_FIRST) ? '0 : count - CNT_ONE;
              i   <= (act == ACT_DEL_FIRST) ? '0 : count - CNT_ONE;
            end
            ACT_LIST: begin
              ov_status_r <= ST_EMPTY;
              i <= '0;
            end
            ACT_SORT: begin
              ov_status_r <= (count == '0) ? ST_EMPTY : ST_DONE;
              i <= '0;
              j <= CNT_ONE;
            end
            ACT_CLEAR: begin
              ov_status_r <= ST_DONE;
              count <= '0;
            end
            ACT_JOSEPHUS: begin
              ov_status_r <= ST_EMPTY;
              pos    <= '0;
              kshift <= km1;
              rem    <= '0;
              bitc   <= MOD_BITS;
            end
            default: ov_status_r <= ST_DONE;
          endcase
        end
        // Close an insert.
        S_INS_RD: if (ins_done) count <= count + CNT_ONE;
        S_INS_WR: i <= i - CNT_ONE;
        // Close a delete; wrap the Josephus position and restart the remainder.
        S_DEL_RD: if (del_done) begin
          count  <= count - CNT_ONE;
          pos    <= (pos >= count - CNT_ONE) ? '0 : pos;
          kshift <= km1;
          rem    <= '0;
          bitc   <= MOD_BITS;
        end
        S_DEL_WR: i <= i + CNT_ONE;
        // Advance the search for the match.
        S_SRCH_CMP: begin
          if (src_hit) begin
            if (count == CNT_FULL) begin
              ov_status_r <= ST_FULL;
            end else begin
              ov_status_r <= ST_DONE;
              pos <= i + CNT_ONE;
              i   <= count;
            end
          end else if (at_end) begin
            ov_status_r <= ST_NOTFOUND;
          end else begin
            i <= i + CNT_ONE;
          end
        end
        S_LIST_EMIT: if (out_free && !at_end) i <= i + CNT_ONE;
        // Hold the value at i for the second half of a swap, then advance.
        S_SORT_CMP: begin
          tmp <= da;
          if (!sort_swap) begin
            if (j + CNT_ONE < count) begin
              j <= j + CNT_ONE;
            end else begin
              i <= i + CNT_ONE;
              j <= i + CNT_TWO;
            end
          end
        end
        S_SORT_SWAP: begin
          if (j + CNT_ONE < count) begin
            j <= j + CNT_ONE;
          end else begin
            i <= i + CNT_ONE;
            j <= i + CNT_TWO;
          end
        end
        // Remainder of (step - 1) by count, one bit a cycle, then the new position.
        S_JOS_MOD: begin
          if (bitc == 5'd0) begin
            pos <= (pos_sum >= {1'b0, count}) ? pos_sub[CW-1:0] : pos_sum[CW-1:0];
          end else begin
            bitc   <= bitc - 5'd1;
            kshift <= {kshift[14:0], 1'b0};
            rem    <= (rem_shift >= {1'b0, count}) ? rem_sub[CW-1:0] : rem_shift[CW-1:0];
          end
        end
        S_JOS_EMIT: if (out_free) i <= pos;
        default: ;
      endcase
    end
  end

  // Memory addressing and result loads.
  always_comb begin
    we = 1'b0; waddr = AW'(i); wdata = da;
    ra = AW'(i); rb = AW'(j);
    ov_load = 1'b0; ov_status = ST_DONE; ov_item = '0; ov_last = 1'b1;
    unique case (state)
      S_INS_RD: begin
        ra = AW'(i - CNT_ONE);
        if (ins_done) begin
          we = 1'b1; waddr = AW'(pos); wdata = val;
        end
      end
      S_INS_WR: we = 1'b1;
      S_DEL_RD: ra = AW'(i + CNT_ONE);
      S_DEL_WR: we = 1'b1;
      S_LIST_EMIT: begin
        ov_load = out_free; ov_status = ST_LISTED; ov_item = da;
        ov_last = at_end;
      end
      S_SORT_CMP: begin
        if (sort_swap) begin
          we = 1'b1; wdata = db;
        end
      end
      S_SORT_SWAP: begin
        we = 1'b1; waddr = AW'(j); wdata = tmp;
      end
      S_JOS_RD: ra = AW'(pos);
      S_JOS_EMIT: begin
        ra = AW'(pos);
        ov_load = out_free;
        ov_status = (count == CNT_ONE) ? ST_SURV : ST_ELIM;
        ov_item = da;
        ov_last = (count == CNT_ONE);
      end
      S_EMIT: begin
        ov_load = out_free; ov_status = ov_status_r;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(item) && $stable(status)
    && $stable(last))
    else $error("result changed while stalled");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL) else $error("entry count beyond capacity");
  a_idle_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("request not taken");
`endif
endmodule
`default_nettype wire
